// ===== hdl/ootx_bit_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// ootx_bit_deframer_core_defines.svh
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef OOTX_BIT_DEFRAMER_CORE_DEFINES_SVH
`define OOTX_BIT_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define OOTX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OOTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define OOTX_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ootx_dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ootx_dfr_pkg
// Types and constants for the OOTX bit deframer.
// ----------------------------------------------------------------------------
package ootx_dfr_pkg;

  // Frame geometry
  localparam int          FRAME_BYTES_DEF = 41;
  localparam int          WORD_BITS       = 16;
  localparam logic [15:0] EXP_LEN_RST     = 16'd33;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_SYNC     = 3'd2,
    ST_PREAMBLE = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_PADDING  = 3'd5
  } status_t;

  // One result word
  typedef struct packed {
    logic [7:0]  station_mode;
    logic [7:0]  hardware_version;
    logic [31:0] station_uuid;
    logic [9:0]  firmware_version;
    logic [5:0]  protocol_version;
    status_t     status;
  } dfr_result_t;

endpackage

// ===== hdl/ootx_bit_deframer_core.sv =====
// ----------------------------------------------------------------------------
// ootx_bit_deframer_core
// OOTX bit deframer: 16 data bits plus a sync bit per word, frame checks
// on sync, preamble, length and padding, field report at frame end.
//
//   channel  dir  handshake          payload
//   in_      in   in_tvalid/tready   in_tdata[0] data_bit
//   out_     out  out_tvalid/tready  out_tuser status, out_tdata fields
//   cfg_     in   cfg_valid/ready    cfg_data expected_length
//
// One result word per input bit; one bit accepted every cycle unless in_tready
// is low. Each result word is registered into the result register or skid entry.
// The result register plus one skid entry absorb output stalls; in_tready
// drops only while the skid entry holds a word.
// rst_n is synchronous; it clears the frame state and sets the length to 33.
// ----------------------------------------------------------------------------
module ootx_bit_deframer_core #(
  parameter int FRAME_BYTES = ootx_dfr_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input bits
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] data_bit, [7:1] zero
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [5:0] protocol_version, [15:6] firmware_version,
                                  // [47:16] station_uuid, [55:48] hardware_version,
                                  // [63:56] station_mode
  output logic [2:0]  out_tuser,  // [2:0] status
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // expected_length
);
  import ootx_dfr_pkg::*;

  logic        bit_we;
  dfr_result_t core_result;
  dfr_result_t out_result;

  assign cfg_ready = 1'b1;
  assign bit_we    = in_tvalid && in_tready;

  ootx_dfr_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .bit_we   (bit_we),
    .data_bit (in_tdata[0]),
    .result   (core_result)
  );

  ootx_dfr_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (bit_we),
    .wr_data  (core_result),
    .wr_ready (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_result)
  );

  // Stream packing
  assign out_tuser = out_result.status;
  assign out_tdata = {out_result.station_mode, out_result.hardware_version,
                      out_result.station_uuid, out_result.firmware_version,
                      out_result.protocol_version};

endmodule

// ===== hdl/ootx_dfr_core.sv =====
// ----------------------------------------------------------------------------
// ootx_dfr_core
// Frame state, per-bit checks and field capture. One bit in per cycle,
// result formed combinationally from the current state and the new bit.
// ----------------------------------------------------------------------------
module ootx_dfr_core #(
  parameter int FRAME_BYTES = ootx_dfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_data,
  input  logic                      bit_we,
  input  logic                      data_bit,
  output ootx_dfr_pkg::dfr_result_t result
);
  import ootx_dfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam int SUM_W = $clog2(FRAME_BYTES + 2);
  localparam int BIT_W = $clog2(WORD_BITS + 1);

  // Byte position of the high byte of the word that carries each capture
  localparam logic [7:0] POS_VER_HI = 8'd2;
  localparam logic [7:0] POS_VER_LO = 8'd4;
  localparam logic [7:0] POS_UUID_M = 8'd6;
  localparam logic [7:0] POS_UUID_L = 8'd8;
  localparam logic [7:0] POS_HW     = 8'd18;
  localparam logic [7:0] POS_MODE   = 8'd34;
  localparam logic [7:0] POS_PAD    = 8'd36;

  logic [15:0]      exp_len_r;
  logic [15:0]      word_shift_r;
  logic [BIT_W-1:0] bit_count_r;
  logic [CNT_W-1:0] byte_count_r;
  logic [15:0]      version_r;
  logic [31:0]      uuid_r;
  logic [7:0]       hw_r;
  logic [7:0]       mode_r;

  logic             sync_phase;
  logic [7:0]       hi_byte;
  logic [7:0]       lo_byte;
  logic [7:0]       old_pos;
  logic [SUM_W-1:0] now_cnt;
  logic [15:0]      version_nxt;
  logic [31:0]      uuid_nxt;
  logic [7:0]       hw_nxt;
  logic [7:0]       mode_nxt;
  status_t          status;

  assign sync_phase = (bit_count_r == BIT_W'(WORD_BITS));
  assign hi_byte    = word_shift_r[15:8];
  assign lo_byte    = word_shift_r[7:0];
  assign old_pos    = 8'(byte_count_r);
  assign now_cnt    = SUM_W'(byte_count_r) + SUM_W'(2);

  // Capture of the fixed byte positions from the word being closed
  always_comb begin
    version_nxt = version_r;
    uuid_nxt    = uuid_r;
    hw_nxt      = hw_r;
    mode_nxt    = mode_r;
    if (old_pos == POS_VER_HI) version_nxt[15:8] = lo_byte;
    if (old_pos == POS_VER_LO) begin
      version_nxt[7:0] = hi_byte;
      uuid_nxt[31:24]  = lo_byte;
    end
    if (old_pos == POS_UUID_M) begin
      uuid_nxt[23:16] = hi_byte;
      uuid_nxt[15:8]  = lo_byte;
    end
    if (old_pos == POS_UUID_L) uuid_nxt[7:0] = hi_byte;
    if (old_pos == POS_HW)     hw_nxt = hi_byte;
    if (old_pos == POS_MODE)   mode_nxt = hi_byte;
  end

  // Checks, first failing one wins
  always_comb begin
    status = ST_BUSY;
    if (sync_phase) begin
      if (!data_bit) begin
        status = ST_SYNC;
      end else if (now_cnt == SUM_W'(2) && word_shift_r != 16'd0) begin
        status = ST_PREAMBLE;
      end else if (now_cnt == SUM_W'(4) && word_shift_r != exp_len_r) begin
        status = ST_LENGTH;
      end else if (old_pos == POS_PAD && hi_byte != 8'd0) begin
        status = ST_PADDING;
      end else if (now_cnt >= SUM_W'(FRAME_BYTES)) begin
        status = ST_DONE;
      end
    end
  end

  // Result fields, zero unless the frame completed
  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_DONE) begin
      result.protocol_version = version_nxt[15:10];
      result.firmware_version = version_nxt[9:0];
      result.station_uuid     = uuid_nxt;
      result.hardware_version = hw_nxt;
      result.station_mode     = mode_nxt;
    end
  end

  // Frame state and length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r    <= EXP_LEN_RST;
      word_shift_r <= '0;
      bit_count_r  <= '0;
      byte_count_r <= '0;
      version_r    <= '0;
      uuid_r       <= '0;
      hw_r         <= '0;
      mode_r       <= '0;
    end else begin
      if (cfg_we) exp_len_r <= cfg_data;
      if (bit_we) begin
        if (!sync_phase) begin
          word_shift_r <= {word_shift_r[14:0], data_bit};
          bit_count_r  <= bit_count_r + BIT_W'(1);
        end else if (status == ST_BUSY) begin
          word_shift_r <= '0;
          bit_count_r  <= '0;
          byte_count_r <= now_cnt[CNT_W-1:0];
          version_r    <= version_nxt;
          uuid_r       <= uuid_nxt;
          hw_r         <= hw_nxt;
          mode_r       <= mode_nxt;
        end else begin
          word_shift_r <= '0;
          bit_count_r  <= '0;
          byte_count_r <= '0;
          version_r    <= '0;
          uuid_r       <= '0;
          hw_r         <= '0;
          mode_r       <= '0;
        end
      end
    end
  end

endmodule

// ===== hdl/ootx_dfr_skid.sv =====
// ----------------------------------------------------------------------------
// ootx_dfr_skid
// Result register with one skid entry, so a stalled output never costs
// an input cycle until the skid entry itself is full.
// ----------------------------------------------------------------------------
module ootx_dfr_skid (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  ootx_dfr_pkg::dfr_result_t wr_data,
  output logic                      wr_ready,
  output logic                      rd_valid,
  input  logic                      rd_ready,
  output ootx_dfr_pkg::dfr_result_t rd_data
);
  import ootx_dfr_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  dfr_result_t out_data_r;
  dfr_result_t skid_data_r;

  assign wr_ready = !skid_valid_r;
  assign rd_valid = out_valid_r;
  assign rd_data  = out_data_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (rd_ready) skid_valid_r <= 1'b0;
    end else if (wr_en) begin
      if (out_valid_r && !rd_ready) skid_valid_r <= 1'b1;
      else                          out_valid_r  <= 1'b1;
    end else if (rd_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (rd_ready) out_data_r <= skid_data_r;
    end else if (wr_en) begin
      if (out_valid_r && !rd_ready) skid_data_r <= wr_data;
      else                          out_data_r  <= wr_data;
    end
  end

endmodule

// ===== hdl/ootx_dfr_checker.sv =====
// ----------------------------------------------------------------------------
// ootx_dfr_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ootx_bit_deframer_core_defines.svh"

module ootx_dfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import ootx_dfr_pkg::*;

  // Stalled result word stays up
  `OOTX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out word dropped while stalled")

  // Every accepted bit shows a result next cycle
  `OOTX_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_tvalid && in_tready, out_tvalid, "accepted bit gave no result")

  // Fields are zero unless the frame completed
  `OOTX_ASSERT_NOW(a_fields_zero, clk, rst_n, out_tvalid && out_tuser != ST_DONE, out_tdata == 64'd0, "fields set without frame end")

  // Reset empties the output
  `OOTX_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, !rst_n, !out_tvalid, "out valid after reset")

endmodule

bind ootx_bit_deframer_core ootx_dfr_checker u_dfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/ootx_bit_deframer_core_tb.sv =====
// ----------------------------------------------------------------------------
// ootx_bit_deframer_core_tb
// Self-checking bench for the OOTX bit deframer.
//
// Feeds serial bits one word at a time. About half of the random frame choices
// are whole good frames with random content, and the rest are broken frames and
// bit noise. A built-in frame decoder predicts the status and fields of every
// result word, and each result is checked field by field. The expected length
// is run at its reset value, at both extremes and at a random value. Both sides
// of the bench insert random gaps.
// ----------------------------------------------------------------------------
module ootx_bit_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ootx_dfr_pkg::*;

  localparam int FRAME_LEN   = FRAME_BYTES_DEF;
  localparam int FRAME_WORDS = (FRAME_LEN + 1) / 2;  // two bytes per checked word
  localparam int PAD_BYTE    = 36;                    // byte that must stay zero
  localparam int PAD_WORD    = PAD_BYTE / 2;
  localparam int MAX_GAP     = 16;
  localparam int STALL_LIMIT = 2000;                  // cycles with no handshake at all
  localparam int REPORT_CAP  = 40;

  // Kinds of generated frame
  typedef enum int {FR_GOOD, FR_PREAMBLE, FR_LENGTH, FR_PADDING, FR_SYNC} frame_fault_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] data_bit, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [5:0] protocol_version, [15:6] firmware_version,
                           // [47:16] station_uuid, [55:48] hardware_version,
                           // [63:56] station_mode
  logic [2:0]  out_tuser;  // [2:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;   // expected_length

  ootx_bit_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Decoder state
  logic [15:0] dfr_shift;
  int          dfr_bits;
  int          dfr_bytes;
  logic [15:0] dfr_version;
  logic [31:0] dfr_uuid;
  logic [7:0]  dfr_hw;
  logic [7:0]  dfr_mode;
  logic [15:0] dfr_len;

  dfr_result_t pending_results[$];

  int  mismatches   = 0;
  int  bits_sent    = 0;
  int  results_seen = 0;
  int  frames_done  = 0;
  int  rx_hold      = 0;
  bit  rx_calm      = 0;
  bit  in_calm      = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder

  function automatic void clear_frame();
    dfr_shift   = '0;
    dfr_bits    = 0;
    dfr_bytes   = 0;
    dfr_version = '0;
    dfr_uuid    = '0;
    dfr_hw      = '0;
    dfr_mode    = '0;
  endfunction

  // Keep the bytes that the report needs
  function automatic void store_byte(input int pos, input logic [7:0] b);
    if (pos == 3) dfr_version[15:8] = b;
    else if (pos == 4) dfr_version[7:0] = b;
    else if (pos >= 5 && pos <= 8) dfr_uuid[(8 - pos) * 8 +: 8] = b;
    else if (pos == 18) dfr_hw = b;
    else if (pos == 34) dfr_mode = b;
  endfunction

  // Advance the decoder by one bit and return the result word it gives
  function automatic dfr_result_t deframe_bit(input logic b);
    dfr_result_t r;
    logic [15:0] w;
    int          old_cnt;
    int          new_cnt;
    r = '0;
    r.status = ST_BUSY;
    if (dfr_bits < WORD_BITS) begin
      dfr_shift = {dfr_shift[14:0], b};
      dfr_bits++;
    end else if (!b) begin
      r.status = ST_SYNC;
      clear_frame();
    end else begin
      w         = dfr_shift;
      old_cnt   = dfr_bytes;
      new_cnt   = old_cnt + 2;
      dfr_shift = '0;
      dfr_bits  = 0;
      store_byte(old_cnt, w[15:8]);
      store_byte(old_cnt + 1, w[7:0]);
      // checks in priority order; the first failure wins
      if (new_cnt == 2 && w != 16'h0) r.status = ST_PREAMBLE;
      else if (new_cnt == 4 && w != dfr_len) r.status = ST_LENGTH;
      else if (old_cnt == PAD_BYTE && w[15:8] != 8'h0) r.status = ST_PADDING;
      else if (new_cnt >= FRAME_LEN) begin
        r.status           = ST_DONE;
        r.protocol_version = dfr_version[15:10];
        r.firmware_version = dfr_version[9:0];
        r.station_uuid     = dfr_uuid;
        r.hardware_version = dfr_hw;
        r.station_mode     = dfr_mode;
      end
      if (r.status != ST_BUSY) clear_frame();
      else dfr_bytes = new_cnt % 64;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Result side: compare each accepted word with the oldest prediction
  always @(posedge clk) begin : check_results
    dfr_result_t got;
    dfr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no bit pending", 32'(got.status), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.protocol_version !== want.protocol_version)
          report_mismatch("protocol_version", 32'(got.protocol_version),
                          32'(want.protocol_version));
        if (got.firmware_version !== want.firmware_version)
          report_mismatch("firmware_version", 32'(got.firmware_version),
                          32'(want.firmware_version));
        if (got.station_uuid !== want.station_uuid)
          report_mismatch("station_uuid", got.station_uuid, want.station_uuid);
        if (got.hardware_version !== want.hardware_version)
          report_mismatch("hardware_version", 32'(got.hardware_version),
                          32'(want.hardware_version));
        if (got.station_mode !== want.station_mode)
          report_mismatch("station_mode", 32'(got.station_mode), 32'(want.station_mode));
        if (want.status == ST_DONE) frames_done++;
      end
      results_seen++;
      // stall before the next word; now and then switch stalling off or on
      rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
    end
  end

  // Result side ready
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // Send one bit; called and returns at a falling edge
  task automatic send_bit(input logic b);
    int          gap;
    dfr_result_t predicted;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = deframe_bit(b);
    pending_results.insert(pending_results.size(), predicted);
    bits_sent++;
    @(negedge clk);
  endtask

  // 16 data bits, most significant first, then the sync bit
  task automatic send_word(input logic [15:0] w, input logic sync);
    int k;
    for (k = 15; k >= 0; k--) send_bit(w[k]);
    send_bit(sync);
  endtask

  // Random bytes half the time, all-zero or all-one bytes otherwise
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input frame_fault_t fault);
    logic [7:0]  fb [0:FRAME_WORDS*2-1];
    logic [15:0] len_field;
    logic [15:0] flip;
    int          last_word;
    int          bad_sync;
    int          i;
    // start on a frame boundary: force a sync error when mid-frame
    if (dfr_bits != 0 || dfr_bytes != 0) begin
      while (dfr_bits < WORD_BITS) send_bit(1'($urandom_range(0, 1)));
      send_bit(1'b0);
    end
    for (i = 0; i < FRAME_WORDS * 2; i++) fb[i] = rand_byte();
    fb[0]        = 8'h00;
    fb[1]        = 8'h00;
    fb[PAD_BYTE] = 8'h00;
    len_field    = dfr_len;
    last_word    = FRAME_WORDS - 1;
    bad_sync     = -1;
    // a broken frame stops at the word that breaks it
    case (fault)
      FR_PREAMBLE: begin
        fb[$urandom_range(0, 1)] = 8'($urandom_range(1, 255));
        last_word = 0;
      end
      FR_LENGTH: begin
        flip = 16'($urandom_range(1, 65535));
        len_field = dfr_len ^ flip;
        last_word = 1;
      end
      FR_PADDING: begin
        fb[PAD_BYTE] = 8'($urandom_range(1, 255));
        last_word = PAD_WORD;
      end
      FR_SYNC: begin
        bad_sync  = $urandom_range(0, FRAME_WORDS - 1);
        last_word = bad_sync;
      end
      default: ;
    endcase
    {fb[2], fb[3]} = len_field;
    for (i = 0; i <= last_word; i++) send_word({fb[2*i], fb[2*i+1]}, i != bad_sync);
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_length(input logic [15:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dfr_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // All ones in the data bits, then a zero where the sync bit belongs
  task automatic test_sync_error();
    in_calm = 1'b0;
    send_word(16'hFFFF, 1'b0);
  endtask

  // One frame for each check, then a good one, at the reset length
  task automatic test_each_check();
    send_frame(FR_PREAMBLE);
    send_frame(FR_LENGTH);
    send_frame(FR_PADDING);
    send_frame(FR_SYNC);
    in_calm = 1'b1;
    send_frame(FR_GOOD);
  endtask

  // Random mix of frames and noise at one length setting
  task automatic test_length_setting(input logic [15:0] len, input int n_bits);
    int start;
    drain_results();
    write_length(len);
    start = bits_sent;
    while (bits_sent - start < n_bits) begin
      in_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        5:       send_frame(FR_PREAMBLE);
        6:       send_frame(FR_LENGTH);
        7:       send_frame(FR_PADDING);
        8:       send_frame(FR_SYNC);
        9:       repeat ($urandom_range(1, 40)) send_bit(1'($urandom_range(0, 1)));
        default: send_frame(FR_GOOD);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    logic [15:0] any_len;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    clear_frame();
    dfr_len = EXP_LEN_RST;
    any_len = 16'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_sync_error();
    test_each_check();
    test_length_setting(16'h0000, 60);
    test_length_setting(16'hFFFF, 60);
    test_length_setting(any_len, 60);
    test_length_setting(EXP_LEN_RST, 60);

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered: %0d bits, %0d results checked, %0d frames completed",
             bits_sent, results_seen, frames_done);
    $display("lengths used: 33, 0, 0xffff and 0x%0h; %0d mismatches", any_len, mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
